/* rtl/core/dpst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense Prim spanning tree package
// Shared widths and constants for the spanning tree core.
// ----------------------------------------------------------------------------
package dpst_pkg;

  localparam int MaxNodes  = 64;
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int AddrW     = 2 * NodeW;
  localparam int CountW    = 7;
  localparam int DistW     = 31;
  localparam int PosW      = AddrW + 1;

  localparam logic [DistW-1:0] FarAway = 31'd2000000000;

endpackage

/* rtl/core/dense_prim_spanning_tree_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense Prim spanning tree core
// Loads an n-by-n distance matrix and emits the minimum spanning tree edges.
// ----------------------------------------------------------------------------
// Each distance beat is written into the matrix memory as it is taken, so a
// matrix of n nodes takes n*n beats. On the last beat of a matrix the core
// stops taking beats and runs Prim's algorithm from node 0. Distances and
// parents live in a node memory with a registered read. Every round finds the
// nearest node outside the tree (StSelRd and StSel for each node), marks it
// (StMark) and relaxes its row (StRelaxRd and StRelax for each node). The
// matrix memory is read one entry per cycle. Up to n rounds run, followed by
// one closing selection pass. The edge scan then visits each of the n(n-1)/2
// pairs through StScan and StScanChk; each edge found adds a weight read and
// an emit that waits while the output is stalled. Nodes without a parent read
// as the starting distance, so no clearing pass is needed after reset.
module dense_prim_spanning_tree_core
  import dpst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] node_count_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DistW-1:0]  distance_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CountW-1:0] node_a_o,
  output logic [CountW-1:0] node_b_o,
  output logic [DistW-1:0]  edge_weight_o,
  output logic              last_edge_o
);

  typedef enum logic [3:0] {
    StLoad, StInit, StSelRd, StSel, StMark, StRelaxRd, StRelax, StScan,
    StScanChk, StWtRd, StWtWait, StEmit
  } state_e;

  typedef struct packed {
    logic [NodeW-1:0] par;
    logic [DistW-1:0] best;
  } node_t;

  state_e            state_q;
  logic [CountW-1:0] ncfg_q;
  logic [PosW-1:0]   pos_q;
  logic [NodeW:0]    n;
  logic [PosW-1:0]   total;

  // Membership and parent flags; a node without a parent still has its
  // starting distance, so the node memory never needs clearing.
  logic [MaxNodes-1:0] in_tree_q;
  logic [MaxNodes-1:0] has_par_q;

  logic [NodeW:0]    i_q, j_q;
  logic [NodeW-1:0]  pick_q;
  logic              found_q;
  logic [DistW-1:0]  bestv_q;
  logic              pend_q, last_q;
  logic [NodeW-1:0]  pa_q, pb_q;
  logic [DistW-1:0]  w_q;
  logic [NodeW-1:0]  ii, jj;

  // Matrix memory with a registered read port.
  logic [DistW-1:0] mem [MaxNodes*MaxNodes];
  logic [DistW-1:0] rdata_q;
  logic [AddrW-1:0] raddr;
  logic             wen;

  // Node memory with two registered read ports and one write port.
  node_t            node_mem [MaxNodes];
  node_t            na_q, nb_q;
  logic [DistW-1:0] cur_best;
  logic             node_we;
  logic             emit_go;

  always_comb begin
    if (ncfg_q == '0) n = (NodeW+1)'(1);
    else if (ncfg_q > CountW'(MaxNodes)) n = (NodeW+1)'(MaxNodes);
    else n = ncfg_q[NodeW:0];
  end
  assign total = PosW'(n) * PosW'(n);

  assign cfg_ready_o = (state_q == StLoad);
  assign in_stall_o  = (state_q != StLoad) || cfg_valid_i;
  assign wen         = in_valid_i && !in_stall_o;

  assign ii = i_q[NodeW-1:0];
  assign jj = j_q[NodeW-1:0];

  // Address of a row-major entry: row * n + column.
  function automatic logic [AddrW-1:0] rc(input logic [NodeW-1:0] r,
                                          input logic [NodeW-1:0] c,
                                          input logic [NodeW:0] nn);
    logic [PosW-1:0] t;
    t = PosW'(r) * PosW'(nn) + PosW'(c);
    return t[AddrW-1:0];
  endfunction

  always_comb begin
    raddr = rc(pick_q, ii, n);
    if (state_q == StWtRd) raddr = rc(pa_q, pb_q, n);
  end

  always_ff @(posedge clk_i) begin
    if (wen) mem[pos_q[AddrW-1:0]] <= distance_i;
    rdata_q <= mem[raddr];
  end

  // Tentative distance of the node read last cycle.
  always_comb begin
    if (has_par_q[ii]) cur_best = na_q.best;
    else if (ii == '0) cur_best = '0;
    else cur_best = FarAway;
  end

  assign node_we = (state_q == StRelax) && !in_tree_q[ii] && (rdata_q < cur_best);
  assign emit_go = (state_q == StEmit) && (!out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[ii] <= '{par: pick_q, best: rdata_q};
    na_q <= node_mem[ii];
    nb_q <= node_mem[jj];
  end

  // Sequencer for loading, selection, relaxation and the edge scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      ncfg_q      <= CountW'(MaxNodes);
      pos_q       <= '0;
      in_tree_q   <= '0;
      has_par_q   <= '0;
      i_q         <= '0;
      j_q         <= '0;
      pick_q      <= '0;
      found_q     <= 1'b0;
      bestv_q     <= FarAway;
      pend_q      <= 1'b0;
      last_q      <= 1'b0;
      pa_q        <= '0;
      pb_q        <= '0;
      w_q         <= '0;
      out_valid_o <= 1'b0;
      node_a_o    <= '0;
      node_b_o    <= '0;
      edge_weight_o <= '0;
      last_edge_o <= 1'b0;
    end else begin
      // The output beat is loaded from the held edge and dropped once taken.
      if (emit_go) begin
        out_valid_o   <= 1'b1;
        node_a_o      <= (pa_q < pb_q) ? CountW'(pa_q) + CountW'(1)
                                       : CountW'(pb_q) + CountW'(1);
        node_b_o      <= (pa_q < pb_q) ? CountW'(pb_q) + CountW'(1)
                                       : CountW'(pa_q) + CountW'(1);
        edge_weight_o <= w_q;
        last_edge_o   <= last_q;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        StLoad: begin
          if (cfg_valid_i) begin
            ncfg_q <= node_count_i;
            pos_q  <= '0;
          end else if (wen) begin
            if (pos_q + PosW'(1) >= total) begin
              pos_q   <= '0;
              state_q <= StInit;
            end else begin
              pos_q <= pos_q + PosW'(1);
            end
          end
        end
        StInit: begin
          in_tree_q <= '0;
          has_par_q <= '0;
          i_q <= '0; found_q <= 1'b0; bestv_q <= FarAway;
          state_q <= StSelRd;
        end
        StSelRd: begin
          // Node i is read here; its distance is compared next cycle.
          if (i_q == n) begin
            if (found_q) state_q <= StMark;
            else begin
              i_q <= '0; j_q <= (NodeW+1)'(1); pend_q <= 1'b0;
              state_q <= StScan;
            end
          end else begin
            state_q <= StSel;
          end
        end
        StSel: begin
          if (!in_tree_q[ii] && cur_best < bestv_q) begin
            bestv_q <= cur_best; pick_q <= ii; found_q <= 1'b1;
          end
          i_q <= i_q + (NodeW+1)'(1);
          state_q <= StSelRd;
        end
        StMark: begin
          in_tree_q[pick_q] <= 1'b1;
          i_q <= '0;
          state_q <= StRelaxRd;
        end
        StRelaxRd: begin
          // Matrix entry and node i are read; data lands next cycle.
          state_q <= StRelax;
        end
        StRelax: begin
          if (node_we) has_par_q[ii] <= 1'b1;
          if (i_q + (NodeW+1)'(1) == n) begin
            i_q <= '0; found_q <= 1'b0; bestv_q <= FarAway;
            state_q <= StSelRd;
          end else begin
            i_q <= i_q + (NodeW+1)'(1);
            state_q <= StRelaxRd;
          end
        end
        StScan: begin
          // Walk pairs a<b; the parents of both nodes are read here.
          if (j_q >= n) begin
            if (i_q + (NodeW+1)'(1) >= n) begin
              if (pend_q) begin
                last_q <= 1'b1; state_q <= StEmit;
              end else state_q <= StLoad;
            end else begin
              i_q <= i_q + (NodeW+1)'(1); j_q <= i_q + (NodeW+1)'(2);
            end
          end else begin
            state_q <= StScanChk;
          end
        end
        StScanChk: begin
          // A held edge is emitted once the next one is known.
          if (in_tree_q[jj] && has_par_q[jj] && nb_q.par == ii) begin
            if (pend_q) begin
              last_q <= 1'b0; state_q <= StEmit;
            end else begin
              pa_q <= ii; pb_q <= jj; pend_q <= 1'b1;
              state_q <= StWtRd;
            end
          end else if (in_tree_q[ii] && has_par_q[ii] && na_q.par == jj) begin
            if (pend_q) begin
              last_q <= 1'b0; state_q <= StEmit;
            end else begin
              pa_q <= jj; pb_q <= ii; pend_q <= 1'b1;
              state_q <= StWtRd;
            end
          end else begin
            j_q <= j_q + (NodeW+1)'(1);
            state_q <= StScan;
          end
        end
        StWtRd: begin
          // Weight read at [parent][child]; pa/pb hold parent/child here.
          state_q <= StWtWait;
        end
        StWtWait: begin
          w_q <= rdata_q;
          j_q <= j_q + (NodeW+1)'(1);
          state_q <= StScan;
        end
        StEmit: begin
          if (emit_go) begin
            pend_q  <= 1'b0;
            state_q <= last_q ? StLoad : StScan;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> in_stall_o) else $error("beat taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(edge_weight_o)))
    else $error("stalled edge changed");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (node_a_o < node_b_o)) else $error("edge endpoints out of order");
`endif

endmodule
